/* design/prec_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Point region exclusion classifier package
// Shared constants, command codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package prec_pkg;

    localparam int COORD_W    = 32;   // Q16.16 coordinate width
    localparam int TOL_W      = 31;   // edge tolerance width
    localparam int COUNT_W    = 4;    // region_count register width
    localparam int CNT_W      = 7;    // wide enough for any region count setting
    localparam int NODE_W     = 16;   // node_index field width
    localparam int NODE_CMP_W = 21;   // wide enough for any node count setting
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Item commands.
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_BUILD = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    // Operating modes.
    localparam logic [1:0] MODE_OFF     = 2'd0;
    localparam logic [1:0] MODE_COMPUTE = 2'd1;
    localparam logic [1:0] MODE_STORED  = 2'd2;

    // Region kinds.
    localparam logic [1:0] KIND_CIRCLE = 2'd1;
    localparam logic [1:0] KIND_RECT   = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MODE         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_X    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Y    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_COUNT = 3'd6;

    // Multiplier operand select.
    localparam logic [1:0] MUL_X = 2'd0;
    localparam logic [1:0] MUL_Y = 2'd1;
    localparam logic [1:0] MUL_Z = 2'd2;
    localparam logic [1:0] MUL_R = 2'd3;

    typedef struct packed {
        logic       latch_item;
        logic       load_region;
        logic       slot_clear;
        logic       slot_inc;
        logic       mag_load;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       acc_load;
        logic       acc_add;
        logic       flag_one;
        logic       flag_zero;
        logic       flag_stored;
        logic       store_write;
        logic       out_load;
    } prec_ctl_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       box_fail;
        logic       count_zero;
        logic       last_slot;
        logic       kind_circle;
        logic       kind_rect;
        logic       rect_hit;
        logic       radius_pos;
        logic       dist_lt;
    } prec_stat_t;

endpackage
`default_nettype wire

/* design/prec_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Classifier controller
// Sequences box check, region walk, multiplier steps, bit store and output.
// ----------------------------------------------------------------------------
module prec_ctrl
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           item_cmd,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output prec_pkg::prec_ctl_t       ctl,
    input  wire prec_pkg::prec_stat_t stat
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_BOX    = 4'd1;
    localparam logic [3:0] S_READ   = 4'd2;
    localparam logic [3:0] S_EVAL   = 4'd3;
    localparam logic [3:0] S_MX     = 4'd4;
    localparam logic [3:0] S_MY     = 4'd5;
    localparam logic [3:0] S_MZ     = 4'd6;
    localparam logic [3:0] S_MR     = 4'd7;
    localparam logic [3:0] S_CMP    = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;
    localparam logic [3:0] S_LOOK   = 4'd10;
    localparam logic [3:0] S_FETCH  = 4'd11;
    localparam logic [3:0] S_FINISH = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       is_build_reg;
    logic       is_build_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        ctl           = '0;
        state_next    = state_reg;
        is_build_next = is_build_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.latch_item = 1'b1;
                    case (item_cmd)
                        prec_pkg::CMD_LOAD:
                        begin
                            ctl.load_region = 1'b1;
                        end
                        prec_pkg::CMD_BUILD:
                        begin
                            is_build_next = 1'b1;
                            state_next    = S_BOX;
                        end
                        prec_pkg::CMD_QUERY:
                        begin
                            is_build_next = 1'b0;
                            if (stat.mode == prec_pkg::MODE_COMPUTE)
                            begin
                                state_next = S_BOX;
                            end
                            else if (stat.mode == prec_pkg::MODE_STORED)
                            begin
                                state_next = S_LOOK;
                            end
                            else
                            begin
                                ctl.flag_one = 1'b1;
                                state_next   = S_FINISH;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_BOX:
            begin
                if (stat.box_fail)
                begin
                    ctl.flag_zero = 1'b1;
                    state_next    = S_DONE;
                end
                else if (stat.count_zero)
                begin
                    ctl.flag_one = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    ctl.slot_clear = 1'b1;
                    state_next     = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (stat.kind_rect && stat.rect_hit)
                begin
                    ctl.flag_zero = 1'b1;
                    state_next    = S_DONE;
                end
                else if (stat.kind_circle && stat.radius_pos)
                begin
                    ctl.mag_load = 1'b1;
                    state_next   = S_MX;
                end
                else if (stat.last_slot)
                begin
                    ctl.flag_one = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    ctl.slot_inc = 1'b1;
                    state_next   = S_READ;
                end
            end
            S_MX:
            begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = prec_pkg::MUL_X;
                state_next  = S_MY;
            end
            S_MY:
            begin
                ctl.mul_en   = 1'b1;
                ctl.mul_sel  = prec_pkg::MUL_Y;
                ctl.acc_load = 1'b1;
                state_next   = S_MZ;
            end
            S_MZ:
            begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = prec_pkg::MUL_Z;
                ctl.acc_add = 1'b1;
                state_next  = S_MR;
            end
            S_MR:
            begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = prec_pkg::MUL_R;
                ctl.acc_add = 1'b1;
                state_next  = S_CMP;
            end
            S_CMP:
            begin
                if (stat.dist_lt)
                begin
                    ctl.flag_zero = 1'b1;
                    state_next    = S_DONE;
                end
                else if (stat.last_slot)
                begin
                    ctl.flag_one = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    ctl.slot_inc = 1'b1;
                    state_next   = S_READ;
                end
            end
            S_DONE:
            begin
                if (is_build_reg)
                begin
                    ctl.store_write = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_LOOK:
            begin
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                ctl.flag_stored = 1'b1;
                state_next      = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (ctl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            is_build_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            is_build_reg  <= is_build_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

/* design/prec_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Classifier datapath
// Configuration registers, region tables, shared squarer and node bit store.
// ----------------------------------------------------------------------------
module prec_datapath
#(
    parameter int MAX_REGIONS = 8,
    parameter int MAX_NODES   = 65536
)
(
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      cfg_write,
    input  wire logic [prec_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  wire logic [prec_pkg::CFG_DATA_W-1:0]           cfg_data,
    input  wire logic [2:0]                                region_slot,
    input  wire logic [1:0]                                region_kind,
    input  wire logic signed [prec_pkg::COORD_W-1:0]       region_a,
    input  wire logic signed [prec_pkg::COORD_W-1:0]       region_b,
    input  wire logic signed [prec_pkg::COORD_W-1:0]       region_c,
    input  wire logic signed [prec_pkg::COORD_W-1:0]       region_d,
    input  wire logic signed [prec_pkg::COORD_W-1:0]       point_x,
    input  wire logic signed [prec_pkg::COORD_W-1:0]       point_y,
    input  wire logic signed [prec_pkg::COORD_W-1:0]       point_z,
    input  wire logic [prec_pkg::NODE_W-1:0]               node_index,
    input  wire prec_pkg::prec_ctl_t                       ctl,
    output prec_pkg::prec_stat_t                           stat,
    output logic                                           interior_flag
);

    localparam int CW      = prec_pkg::COORD_W;
    localparam int DW      = CW + 1;
    localparam int BW      = CW + 2;
    localparam int PW      = 2 * DW;
    localparam int AW      = PW + 1;
    localparam int RAW     = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int NODE_AW = $clog2(MAX_NODES);

    localparam logic [prec_pkg::CNT_W-1:0]      MAX_REG_CNT  = prec_pkg::CNT_W'(MAX_REGIONS);
    localparam logic [prec_pkg::NODE_CMP_W-1:0] MAX_NODE_CNT = prec_pkg::NODE_CMP_W'(MAX_NODES);

    // Configuration registers.
    logic [1:0]                     mode_reg;
    logic signed [CW-1:0]           box_min_x_reg;
    logic signed [CW-1:0]           box_min_y_reg;
    logic signed [CW-1:0]           box_max_x_reg;
    logic signed [CW-1:0]           box_max_y_reg;
    logic [prec_pkg::TOL_W-1:0]     tol_reg;
    logic [prec_pkg::COUNT_W-1:0]   count_reg;

    // Region tables.
    logic [1:0]                     kind_tbl_reg [MAX_REGIONS];
    logic [4*CW-1:0]                value_mem [MAX_REGIONS];
    logic [4*CW-1:0]                row_reg;
    logic [RAW-1:0]                 slot_reg;

    // Latched item and arithmetic state.
    logic signed [CW-1:0]           pt_x_reg;
    logic signed [CW-1:0]           pt_y_reg;
    logic signed [CW-1:0]           pt_z_reg;
    logic [prec_pkg::NODE_W-1:0]    node_reg;
    logic [DW-1:0]                  mag_x_reg;
    logic [DW-1:0]                  mag_y_reg;
    logic [DW-1:0]                  mag_z_reg;
    logic [PW-1:0]                  prod_reg;
    logic [AW-1:0]                  acc_reg;
    logic                           flag_reg;
    logic                           interior_flag_reg;

    // Node bit store.
    logic                           store_mem [MAX_NODES];
    logic                           rd_bit_reg;

    logic signed [CW-1:0]           row_a;
    logic signed [CW-1:0]           row_b;
    logic signed [CW-1:0]           row_c;
    logic signed [CW-1:0]           row_d;
    logic signed [DW-1:0]           diff_x;
    logic signed [DW-1:0]           diff_y;
    logic signed [DW-1:0]           diff_z;
    logic [DW-1:0]                  mag_x;
    logic [DW-1:0]                  mag_y;
    logic [DW-1:0]                  mag_z;
    logic [DW-1:0]                  mul_op;
    logic signed [BW-1:0]           tol_ext;
    logic signed [BW-1:0]           lo_x;
    logic signed [BW-1:0]           lo_y;
    logic signed [BW-1:0]           hi_x;
    logic signed [BW-1:0]           hi_y;
    logic [prec_pkg::CNT_W-1:0]     count_ext;
    logic [prec_pkg::CNT_W-1:0]     count_eff;
    logic                           slot_ok;
    logic [RAW+2:0]                 slot_wide;
    logic [RAW-1:0]                 wr_row;
    logic                           node_ok;
    logic [NODE_AW+prec_pkg::NODE_W-1:0] node_wide;
    logic [NODE_AW-1:0]             node_addr;
    logic [1:0]                     cur_kind;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= prec_pkg::MODE_OFF;
            box_min_x_reg <= '0;
            box_min_y_reg <= '0;
            box_max_x_reg <= '0;
            box_max_y_reg <= '0;
            tol_reg       <= '0;
            count_reg     <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                prec_pkg::REG_MODE:         mode_reg      <= cfg_data[1:0];
                prec_pkg::REG_BOX_MIN_X:    box_min_x_reg <= cfg_data[CW-1:0];
                prec_pkg::REG_BOX_MIN_Y:    box_min_y_reg <= cfg_data[CW-1:0];
                prec_pkg::REG_BOX_MAX_X:    box_max_x_reg <= cfg_data[CW-1:0];
                prec_pkg::REG_BOX_MAX_Y:    box_max_y_reg <= cfg_data[CW-1:0];
                prec_pkg::REG_TOLERANCE:    tol_reg       <= cfg_data[prec_pkg::TOL_W-1:0];
                prec_pkg::REG_REGION_COUNT: count_reg     <= cfg_data[prec_pkg::COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Region load: slots beyond the table are dropped.
    assign slot_ok   = prec_pkg::CNT_W'(region_slot) < MAX_REG_CNT;
    assign slot_wide = {{RAW{1'b0}}, region_slot};
    assign wr_row    = slot_wide[RAW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_REGIONS; i++)
            begin
                kind_tbl_reg[i] <= '0;
            end
        end
        else if (ctl.load_region && slot_ok)
        begin
            kind_tbl_reg[wr_row] <= region_kind;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_region && slot_ok)
        begin
            value_mem[wr_row] <= {region_a, region_b, region_c, region_d};
        end
        row_reg <= value_mem[slot_reg];
    end

    assign row_a    = row_reg[4*CW-1:3*CW];
    assign row_b    = row_reg[3*CW-1:2*CW];
    assign row_c    = row_reg[2*CW-1:CW];
    assign row_d    = row_reg[CW-1:0];
    assign cur_kind = kind_tbl_reg[slot_reg];

    // Box check against the bounds pulled in by the tolerance.
    assign tol_ext = BW'($signed({1'b0, tol_reg}));
    assign lo_x    = BW'(box_min_x_reg) + tol_ext;
    assign lo_y    = BW'(box_min_y_reg) + tol_ext;
    assign hi_x    = BW'(box_max_x_reg) - tol_ext;
    assign hi_y    = BW'(box_max_y_reg) - tol_ext;

    assign count_ext = prec_pkg::CNT_W'(count_reg);
    assign count_eff = (count_ext > MAX_REG_CNT) ? MAX_REG_CNT : count_ext;

    // Distance components for circle regions.
    assign diff_x = DW'(pt_x_reg) - DW'(row_a);
    assign diff_y = DW'(pt_y_reg) - DW'(row_b);
    assign diff_z = DW'(pt_z_reg) - DW'(row_c);
    assign mag_x  = diff_x[DW-1] ? DW'(-diff_x) : DW'(diff_x);
    assign mag_y  = diff_y[DW-1] ? DW'(-diff_y) : DW'(diff_y);
    assign mag_z  = diff_z[DW-1] ? DW'(-diff_z) : DW'(diff_z);

    always_comb
    begin
        case (ctl.mul_sel)
            prec_pkg::MUL_X: mul_op = mag_x_reg;
            prec_pkg::MUL_Y: mul_op = mag_y_reg;
            prec_pkg::MUL_Z: mul_op = mag_z_reg;
            default:         mul_op = {1'b0, row_d};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.latch_item)
        begin
            pt_x_reg <= point_x;
            pt_y_reg <= point_y;
            pt_z_reg <= point_z;
            node_reg <= node_index;
        end
        if (ctl.slot_clear)
        begin
            slot_reg <= '0;
        end
        else if (ctl.slot_inc)
        begin
            slot_reg <= slot_reg + RAW'(1);
        end
        if (ctl.mag_load)
        begin
            mag_x_reg <= mag_x;
            mag_y_reg <= mag_y;
            mag_z_reg <= mag_z;
        end
        if (ctl.mul_en)
        begin
            prod_reg <= PW'(mul_op) * PW'(mul_op);
        end
        if (ctl.acc_load)
        begin
            acc_reg <= AW'(prod_reg);
        end
        else if (ctl.acc_add)
        begin
            acc_reg <= acc_reg + AW'(prod_reg);
        end
        if (ctl.flag_one)
        begin
            flag_reg <= 1'b1;
        end
        else if (ctl.flag_zero)
        begin
            flag_reg <= 1'b0;
        end
        else if (ctl.flag_stored)
        begin
            flag_reg <= rd_bit_reg && node_ok;
        end
        if (ctl.out_load)
        begin
            interior_flag_reg <= flag_reg;
        end
    end

    // Node bit store: nodes outside the store are never written and read as zero.
    assign node_ok   = prec_pkg::NODE_CMP_W'(node_reg) < MAX_NODE_CNT;
    assign node_wide = {{NODE_AW{1'b0}}, node_reg};
    assign node_addr = node_wide[NODE_AW-1:0];

    always_ff @(posedge clk)
    begin
        if (ctl.store_write && node_ok)
        begin
            store_mem[node_addr] <= flag_reg;
        end
        rd_bit_reg <= store_mem[node_addr];
    end

    always_comb
    begin
        stat.mode        = mode_reg;
        stat.box_fail    = (BW'(pt_x_reg) < lo_x) || (BW'(pt_y_reg) < lo_y) ||
                           (BW'(pt_x_reg) > hi_x) || (BW'(pt_y_reg) > hi_y);
        stat.count_zero  = (count_eff == '0);
        stat.last_slot   = (prec_pkg::CNT_W'(slot_reg) + prec_pkg::CNT_W'(1)) == count_eff;
        stat.kind_circle = (cur_kind == prec_pkg::KIND_CIRCLE);
        stat.kind_rect   = (cur_kind == prec_pkg::KIND_RECT);
        stat.rect_hit    = (pt_x_reg >= row_a) && (pt_x_reg <= row_c) &&
                           (pt_y_reg >= row_b) && (pt_y_reg <= row_d);
        stat.radius_pos  = (row_d > $signed(CW'(0)));
        stat.dist_lt     = acc_reg < AW'(prod_reg);
    end

    assign interior_flag = interior_flag_reg;

endmodule
`default_nettype wire

/* design/point_region_exclusion_classifier.sv */
// Timing: a region load completes at its transfer. Compute and build walk the region table
// one slot at a time and stop at the first hit; a circle with a positive radius also takes
// the multiplier steps.
// Throughput: one item at a time, set by the slot walk and the single shared squarer.
// Reset clears the control state, configuration and region kinds; the bit store is not cleared.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Point region exclusion classifier
// Flags a point as interior unless it lies outside the box shrunk by the tolerance or inside a region.
// ----------------------------------------------------------------------------
// Items arrive on a valid/ready channel. A load command writes one region slot
// (kind plus four values) and completes at the transfer. A build command
// classifies the point and writes the answer into the node bit store. A query
// answers 1 in off mode, classifies the point in compute mode, or reads the
// stored bit for the node in stored mode.
//
// Classification first checks the point against the bounding box shrunk by
// the edge tolerance. It then walks the region table one slot per step: a
// rectangle is tested with four signed compares, and a circle is tested by
// squaring the three distance components and the radius through one shared
// multiplier and comparing the accumulated sum with the squared radius.
//
// The result sits in an output register, so the next item is taken while an
// earlier result still waits for its transfer.
// ----------------------------------------------------------------------------
module point_region_exclusion_classifier
#(
    parameter int MAX_REGIONS = 8,
    parameter int MAX_NODES   = 65536
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_write,
    input  wire logic [prec_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [prec_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [1:0]                            cmd,
    input  wire logic [2:0]                            region_slot,
    input  wire logic [1:0]                            region_kind,
    input  wire logic signed [prec_pkg::COORD_W-1:0]   region_a,
    input  wire logic signed [prec_pkg::COORD_W-1:0]   region_b,
    input  wire logic signed [prec_pkg::COORD_W-1:0]   region_c,
    input  wire logic signed [prec_pkg::COORD_W-1:0]   region_d,
    input  wire logic signed [prec_pkg::COORD_W-1:0]   point_x,
    input  wire logic signed [prec_pkg::COORD_W-1:0]   point_y,
    input  wire logic signed [prec_pkg::COORD_W-1:0]   point_z,
    input  wire logic [prec_pkg::NODE_W-1:0]           node_index,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic                                       interior_flag
);

    // Command and status between the sequencer and the datapath.
    prec_pkg::prec_ctl_t  ctl;
    prec_pkg::prec_stat_t stat;

    // The controller owns the handshakes and the step order.
    prec_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .item_cmd  (cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctl       (ctl),
        .stat      (stat)
    );

    // The datapath holds configuration, tables, arithmetic and the bit store.
    prec_datapath
    #(
        .MAX_REGIONS (MAX_REGIONS),
        .MAX_NODES   (MAX_NODES)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .region_slot   (region_slot),
        .region_kind   (region_kind),
        .region_a      (region_a),
        .region_b      (region_b),
        .region_c      (region_c),
        .region_d      (region_d),
        .point_x       (point_x),
        .point_y       (point_y),
        .point_z       (point_z),
        .node_index    (node_index),
        .ctl           (ctl),
        .stat          (stat),
        .interior_flag (interior_flag)
    );

endmodule
`default_nettype wire
